>>> sv/rmdm_pkg.sv
// Package for the register and memory dependency matrix.
// Holds field widths, parameter defaults, the controller state type and
// the command and status structs shared by controller and datapath.
package rmdm_pkg;

	localparam int DEF_PROGRAM_DEPTH = 64;
	localparam int DEF_REG_COUNT     = 32;

	localparam int REG_W      = 5;
	localparam int OFF_W      = 12;
	localparam int MASK_W     = 64;
	localparam int INDEX_W    = 6;
	localparam int ALIAS_SPAN = 4;
	localparam int ENTRY_W    = REG_W + OFF_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_A,
		ST_B,
		ST_C,
		ST_D,
		ST_E,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step_a;
		logic step_b;
		logic step_c;
		logic step_d;
		logic step_e;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic overflow;
		logic scan_done;
	} status_t;

endpackage

>>> sv/rmdm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rmdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/rmdm_ctrl.sv
// Controller of the dependency matrix: sequences table lookups, the memory
// scan and the output handshake. Depends on rmdm_pkg.
module rmdm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rmdm_pkg::status_t status,
	output rmdm_pkg::cmd_t    cmd
);

	import rmdm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.overflow ? ST_DONE : ST_A;
				end
			end
			ST_A: begin
				cmd.step_a = 1'b1;
				state_d    = ST_B;
			end
			ST_B: begin
				cmd.step_b = 1'b1;
				state_d    = ST_C;
			end
			ST_C: begin
				cmd.step_c = 1'b1;
				state_d    = ST_D;
			end
			ST_D: begin
				cmd.step_d = 1'b1;
				state_d    = ST_E;
			end
			ST_E: begin
				cmd.step_e = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> sv/rmdm_dp.sv
// Datapath of the dependency matrix: last-writer and reader-set tables,
// memory entry table with alias scan, masks and output registers.
// Depends on rmdm_pkg and rmdm_ram.
module rmdm_dp #(
	parameter int PROGRAM_DEPTH = rmdm_pkg::DEF_PROGRAM_DEPTH,
	parameter int REG_COUNT     = rmdm_pkg::DEF_REG_COUNT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rmdm_pkg::cmd_t                     cmd,
	output rmdm_pkg::status_t                  status,
	input  logic                               start_program,
	input  logic [rmdm_pkg::REG_W-1:0]         dest_reg,
	input  logic [rmdm_pkg::REG_W-1:0]         src1_reg,
	input  logic [rmdm_pkg::REG_W-1:0]         src2_reg,
	input  logic                               is_memory,
	input  logic                               is_store,
	input  logic signed [rmdm_pkg::OFF_W-1:0]  mem_offset,
	output logic [rmdm_pkg::INDEX_W-1:0]       instr_index,
	output logic [rmdm_pkg::MASK_W-1:0]        raw_mask,
	output logic [rmdm_pkg::MASK_W-1:0]        war_mask,
	output logic [rmdm_pkg::MASK_W-1:0]        waw_mask,
	output logic [rmdm_pkg::MASK_W-1:0]        mem_mask,
	output logic                               window_overflow
);

	import rmdm_pkg::*;

	localparam int IDX_W = $clog2(PROGRAM_DEPTH);
	localparam int CNT_W = $clog2(PROGRAM_DEPTH + 1);
	localparam int RA_W  = $clog2(REG_COUNT);
	localparam logic signed [OFF_W:0] SPAN_POS = (OFF_W + 1)'(ALIAS_SPAN);
	localparam logic signed [OFF_W:0] SPAN_NEG = (OFF_W + 1)'(-ALIAS_SPAN);

	function automatic logic reg_ok(input logic [REG_W-1:0] r);
		return (r != '0) && (int'(r) < REG_COUNT);
	endfunction

	// transaction fields
	logic [RA_W-1:0]         rd_a_q, rs1_a_q, rs2_a_q;
	logic                    rd_ok_q, rs1_ok_q, rs2_ok_q;
	logic [REG_W-1:0]        base_q;
	logic signed [OFF_W-1:0] off_q;
	logic                    mem_q, st_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    ovf_q;
	logic [MASK_W-1:0]       raw_q, war_q, waw_q, mem_mask_q;

	// output registers
	logic [INDEX_W-1:0]      out_index_q;
	logic [MASK_W-1:0]       out_raw_q, out_war_q, out_waw_q, out_mem_q;
	logic                    out_ovf_q;

	// control state
	logic [CNT_W-1:0]        next_q;
	logic                    lw_vld_q [REG_COUNT];
	logic                    rs_vld_q [REG_COUNT];
	logic                    me_vld_q [PROGRAM_DEPTH];
	logic [CNT_W-1:0]        k_q;
	logic                    cmp_v_s1;
	logic [IDX_W-1:0]        cmp_k_s1;

	// table ports
	logic [RA_W-1:0]         lw_raddr, rs_raddr, rs_waddr;
	logic [IDX_W-1:0]        lw_rdata;
	logic [MASK_W-1:0]       rs_rdata, rs_wdata;
	logic                    rs_we;
	logic [ENTRY_W-1:0]      me_rdata;

	logic                    ovf_now;
	logic [MASK_W-1:0]       bit_i;
	logic [CNT_W-1:0]        scan_lim;
	logic                    issue;
	logic [REG_W-1:0]        k_base;
	logic signed [OFF_W-1:0] k_off;
	logic                    k_st;
	logic signed [OFF_W:0]   diff;
	logic                    alias_hit;

	assign ovf_now  = !start_program && (next_q >= CNT_W'(PROGRAM_DEPTH));
	assign bit_i    = MASK_W'(1) << idx_q;
	assign scan_lim = (mem_q && rs1_ok_q) ? CNT_W'(idx_q) : '0;
	assign issue    = cmd.scan && (k_q < scan_lim);

	assign status.overflow  = ovf_now;
	assign status.scan_done = (k_q >= scan_lim) && !cmp_v_s1;

	always_comb begin
		if (cmd.step_a) begin
			lw_raddr = rs1_a_q;
			rs_raddr = rd_a_q;
		end else if (cmd.step_b) begin
			lw_raddr = rs2_a_q;
			rs_raddr = rs1_a_q;
		end else begin
			lw_raddr = rd_a_q;
			rs_raddr = rs2_a_q;
		end
	end

	assign rs_waddr = cmd.step_c ? rs1_a_q : rs2_a_q;
	assign rs_we    = (cmd.step_c && rs1_ok_q) || (cmd.step_e && rs2_ok_q);
	assign rs_wdata = (rs_vld_q[rs_waddr] ? rs_rdata : '0) | bit_i;

	rmdm_ram #(
		.WIDTH(IDX_W),
		.DEPTH(REG_COUNT)
	) u_lw_ram (
		.clk  (clk),
		.we   (cmd.step_e && rd_ok_q),
		.waddr(rd_a_q),
		.wdata(idx_q),
		.raddr(lw_raddr),
		.rdata(lw_rdata)
	);

	rmdm_ram #(
		.WIDTH(MASK_W),
		.DEPTH(REG_COUNT)
	) u_rs_ram (
		.clk  (clk),
		.we   (rs_we),
		.waddr(rs_waddr),
		.wdata(rs_wdata),
		.raddr(rs_raddr),
		.rdata(rs_rdata)
	);

	rmdm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PROGRAM_DEPTH)
	) u_me_ram (
		.clk  (clk),
		.we   (cmd.step_e && mem_q),
		.waddr(idx_q),
		.wdata({st_q, base_q, off_q}),
		.raddr(k_q[IDX_W-1:0]),
		.rdata(me_rdata)
	);

	assign k_st   = me_rdata[ENTRY_W-1];
	assign k_base = me_rdata[OFF_W +: REG_W];
	assign k_off  = me_rdata[OFF_W-1:0];
	assign diff   = $signed({k_off[OFF_W-1], k_off}) - $signed({off_q[OFF_W-1], off_q});
	assign alias_hit = cmp_v_s1 && me_vld_q[cmp_k_s1] && (k_base == base_q)
		&& (diff < SPAN_POS) && (diff > SPAN_NEG) && (k_st || st_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q   <= '0;
			k_q      <= '0;
			cmp_v_s1 <= 1'b0;
			for (int r = 0; r < REG_COUNT; r++) begin
				lw_vld_q[r] <= 1'b0;
				rs_vld_q[r] <= 1'b0;
			end
			for (int e = 0; e < PROGRAM_DEPTH; e++) begin
				me_vld_q[e] <= 1'b0;
			end
		end else begin
			if (cmd.load && start_program) begin
				next_q <= '0;
				for (int r = 0; r < REG_COUNT; r++) begin
					lw_vld_q[r] <= 1'b0;
					rs_vld_q[r] <= 1'b0;
				end
				for (int e = 0; e < PROGRAM_DEPTH; e++) begin
					me_vld_q[e] <= 1'b0;
				end
			end
			if (cmd.step_b && rd_ok_q) begin
				rs_vld_q[rd_a_q] <= 1'b0;
			end
			if (cmd.step_c && rs1_ok_q) begin
				rs_vld_q[rs1_a_q] <= 1'b1;
			end
			if (cmd.step_e) begin
				if (rs2_ok_q) begin
					rs_vld_q[rs2_a_q] <= 1'b1;
				end
				if (rd_ok_q) begin
					lw_vld_q[rd_a_q] <= 1'b1;
				end
				if (mem_q) begin
					me_vld_q[idx_q] <= 1'b1;
				end
				k_q      <= '0;
				cmp_v_s1 <= 1'b0;
			end
			if (cmd.scan) begin
				cmp_v_s1 <= issue;
				if (issue) begin
					k_q <= k_q + 1'b1;
				end
			end
			if (cmd.finish && !ovf_q) begin
				next_q <= CNT_W'(idx_q) + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_a_q     <= RA_W'(dest_reg);
			rs1_a_q    <= RA_W'(src1_reg);
			rs2_a_q    <= RA_W'(src2_reg);
			rd_ok_q    <= reg_ok(dest_reg);
			rs1_ok_q   <= reg_ok(src1_reg);
			rs2_ok_q   <= reg_ok(src2_reg);
			base_q     <= reg_ok(src1_reg) ? src1_reg : '0;
			off_q      <= mem_offset;
			mem_q      <= is_memory;
			st_q       <= is_memory && is_store;
			idx_q      <= (ovf_now || start_program) ? '0 : next_q[IDX_W-1:0];
			ovf_q      <= ovf_now;
			raw_q      <= '0;
			war_q      <= '0;
			waw_q      <= '0;
			mem_mask_q <= '0;
		end
		if (cmd.step_b) begin
			if (rs1_ok_q && lw_vld_q[rs1_a_q]) begin
				raw_q <= raw_q | (MASK_W'(1) << lw_rdata);
			end
			if (rd_ok_q && rs_vld_q[rd_a_q]) begin
				war_q <= rs_rdata;
			end
		end
		if (cmd.step_c && rs2_ok_q && lw_vld_q[rs2_a_q]) begin
			raw_q <= raw_q | (MASK_W'(1) << lw_rdata);
		end
		if (cmd.step_d && rd_ok_q && lw_vld_q[rd_a_q]) begin
			waw_q <= MASK_W'(1) << lw_rdata;
		end
		if (issue) begin
			cmp_k_s1 <= k_q[IDX_W-1:0];
		end
		if (cmd.scan && alias_hit) begin
			mem_mask_q <= mem_mask_q | (MASK_W'(1) << cmp_k_s1);
		end
		if (cmd.finish) begin
			out_index_q <= INDEX_W'(idx_q);
			out_raw_q   <= raw_q;
			out_war_q   <= war_q;
			out_waw_q   <= waw_q;
			out_mem_q   <= mem_mask_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign instr_index     = out_index_q;
	assign raw_mask        = out_raw_q;
	assign war_mask        = out_war_q;
	assign waw_mask        = out_waw_q;
	assign mem_mask        = out_mem_q;
	assign window_overflow = out_ovf_q;

endmodule

>>> sv/register_memory_dependency_matrix_core.sv
// Top level of the register and memory dependency matrix.
// Joins the controller rmdm_ctrl and the datapath rmdm_dp; uses rmdm_pkg.
//
// Usage: one decoded instruction enters per input transaction (in_valid,
// in_stall); one result leaves per output transaction (out_valid, out_stall)
// carrying the instruction index and the RAW, WAR, WAW and memory alias masks
// over earlier instructions of the program. start_program clears all tables
// and makes the instruction number 0.
// After acceptance an instruction steps through states A to E, SCAN and DONE; when
// instruction i > 0 is a load or store with a nonzero base register, the memory
// table is read one entry per cycle through its single read port. A new
// instruction is taken only after the result is registered and the controller
// is back in idle.
// Instructions past the window go straight to the result, flagged with
// window_overflow, and change no state.
// Reset empties all tables at once and drops any pending result.
// While out_stall holds a result, the next instruction is still accepted and
// processed; its result waits until the output register is free.
module register_memory_dependency_matrix_core #(
	parameter int PROGRAM_DEPTH = rmdm_pkg::DEF_PROGRAM_DEPTH,
	parameter int REG_COUNT     = rmdm_pkg::DEF_REG_COUNT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               start_program,
	input  logic [rmdm_pkg::REG_W-1:0]         dest_reg,
	input  logic [rmdm_pkg::REG_W-1:0]         src1_reg,
	input  logic [rmdm_pkg::REG_W-1:0]         src2_reg,
	input  logic                               is_memory,
	input  logic                               is_store,
	input  logic signed [rmdm_pkg::OFF_W-1:0]  mem_offset,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rmdm_pkg::INDEX_W-1:0]       instr_index,
	output logic [rmdm_pkg::MASK_W-1:0]        raw_mask,
	output logic [rmdm_pkg::MASK_W-1:0]        war_mask,
	output logic [rmdm_pkg::MASK_W-1:0]        waw_mask,
	output logic [rmdm_pkg::MASK_W-1:0]        mem_mask,
	output logic                               window_overflow
);

	import rmdm_pkg::*;

	cmd_t    cmd;
	status_t status;

	rmdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rmdm_dp #(
		.PROGRAM_DEPTH(PROGRAM_DEPTH),
		.REG_COUNT    (REG_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.start_program  (start_program),
		.dest_reg       (dest_reg),
		.src1_reg       (src1_reg),
		.src2_reg       (src2_reg),
		.is_memory      (is_memory),
		.is_store       (is_store),
		.mem_offset     (mem_offset),
		.instr_index    (instr_index),
		.raw_mask       (raw_mask),
		.war_mask       (war_mask),
		.waw_mask       (waw_mask),
		.mem_mask       (mem_mask),
		.window_overflow(window_overflow)
	);

endmodule

>>> dv/tb_register_memory_dependency_matrix_core.sv
`timescale 1ns / 1ps
// Testbench for register_memory_dependency_matrix_core: a directed table, then random programs,
// each result checked by a behavioral tracker or fixed edges. Depends on rmdm_pkg and the RTL.
module tb_register_memory_dependency_matrix_core;
	import rmdm_pkg::*;

	localparam int DEPTH      = DEF_PROGRAM_DEPTH;
	localparam int NREGS      = DEF_REG_COUNT;
	localparam int RAND_ITEMS = 1364;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 600;
	localparam int DRAIN      = 80;
	localparam int LIMIT      = 2000000;
	localparam int DIR_ROWS   = 32;
	localparam int DUE_DEPTH  = 16;

	typedef struct packed {
		logic                    start;
		logic [REG_W-1:0]        rd;
		logic [REG_W-1:0]        rs1;
		logic [REG_W-1:0]        rs2;
		logic                    mem;
		logic                    st;
		logic signed [OFF_W-1:0] off;
	} instr_t;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic [MASK_W-1:0]  raw;
		logic [MASK_W-1:0]  war;
		logic [MASK_W-1:0]  waw;
		logic [MASK_W-1:0]  mem;
		logic               ovf;
	} edges_t;

	typedef struct packed {
		instr_t ins;
		int     reps;
		logic   typed;
		edges_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic start_program = 1'b0;
	logic [REG_W-1:0] dest_reg = '0;
	logic [REG_W-1:0] src1_reg = '0;
	logic [REG_W-1:0] src2_reg = '0;
	logic is_memory = 1'b0;
	logic is_store = 1'b0;
	logic signed [OFF_W-1:0] mem_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [INDEX_W-1:0] instr_index;
	logic [MASK_W-1:0] raw_mask;
	logic [MASK_W-1:0] war_mask;
	logic [MASK_W-1:0] waw_mask;
	logic [MASK_W-1:0] mem_mask;
	logic window_overflow;

	register_memory_dependency_matrix_core u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic               wr_known [NREGS];
	logic [INDEX_W-1:0] wr_idx [NREGS];
	logic [MASK_W-1:0]  readers [NREGS];
	logic [REG_W-1:0]   acc_base [DEPTH];
	int                 acc_off [DEPTH];
	logic               acc_st [DEPTH];
	logic [MASK_W-1:0]  acc_live;
	int                 next_pos;

	row_t   dir [DIR_ROWS];
	int     n_rows = 0;
	edges_t due_q [DUE_DEPTH];
	int     due_wr = 0;
	int     due_rd = 0;
	int mismatches = 0;
	int n_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int cycles = 0;

	function automatic void clear_program();
		for (int r = 0; r < NREGS; r++) begin
			wr_known[r] = 1'b0;
			wr_idx[r] = '0;
			readers[r] = '0;
		end
		acc_live = '0;
		next_pos = 0;
	endfunction

	function automatic void add_row(row_t r);
		dir[n_rows] = r;
		n_rows++;
	endfunction

	function automatic void queue_edges(edges_t e);
		due_q[due_wr % DUE_DEPTH] = e;
		due_wr++;
	endfunction

	function automatic int reg_num(logic [REG_W-1:0] r);
		return (int'(r) < NREGS) ? int'(r) : 0;
	endfunction

	function automatic edges_t derive_edges(instr_t it);
		edges_t e;
		int rd, r1, r2, d;
		logic st;
		e = '0;
		rd = reg_num(it.rd);
		r1 = reg_num(it.rs1);
		r2 = reg_num(it.rs2);
		st = it.mem & it.st;
		if (it.start)
			clear_program();
		if (next_pos >= DEPTH) begin
			e.ovf = 1'b1;
			return e;
		end
		e.idx = INDEX_W'(next_pos);
		if (r1 != 0 && wr_known[r1])
			e.raw[wr_idx[r1]] = 1'b1;
		if (r2 != 0 && wr_known[r2])
			e.raw[wr_idx[r2]] = 1'b1;
		if (rd != 0) begin
			if (wr_known[rd])
				e.waw[wr_idx[rd]] = 1'b1;
			e.war = readers[rd];
			readers[rd] = '0;
			wr_known[rd] = 1'b1;
			wr_idx[rd] = INDEX_W'(next_pos);
		end
		if (r1 != 0)
			readers[r1][next_pos] = 1'b1;
		if (r2 != 0)
			readers[r2][next_pos] = 1'b1;
		if (it.mem) begin
			if (r1 != 0) begin
				for (int k = 0; k < next_pos; k++) begin
					d = acc_off[k] - int'($signed(it.off));
					if (acc_live[k] && int'(acc_base[k]) == r1 && d > -ALIAS_SPAN &&
							d < ALIAS_SPAN && (acc_st[k] || st))
						e.mem[k] = 1'b1;
				end
			end
			acc_base[next_pos] = REG_W'(r1);
			acc_off[next_pos] = int'($signed(it.off));
			acc_st[next_pos] = st;
			acc_live[next_pos] = 1'b1;
		end
		next_pos++;
		return e;
	endfunction

	function automatic instr_t make_instr(logic s, int rd, int r1, int r2, logic m, logic st,
			int off);
		instr_t it;
		it.start = s;
		it.rd = REG_W'(rd);
		it.rs1 = REG_W'(r1);
		it.rs2 = REG_W'(r2);
		it.mem = m;
		it.st = st;
		it.off = OFF_W'(off);
		return it;
	endfunction

	function automatic edges_t no_edges(int idx, logic ovf);
		edges_t e;
		e = '0;
		e.idx = INDEX_W'(idx);
		e.ovf = ovf;
		return e;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [MASK_W-1:0] got, logic [MASK_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic send_instr(instr_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_program <= it.start;
		dest_reg <= it.rd;
		src1_reg <= it.rs1;
		src2_reg <= it.rs2;
		is_memory <= it.mem;
		is_store <= it.st;
		mem_offset <= it.off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_sent >= HOLD_AT) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		edges_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_wr == due_rd) begin
				report_mismatch($sformatf("unexpected transaction, index %0d", instr_index));
			end else begin
				want = due_q[due_rd % DUE_DEPTH];
				due_rd++;
				check_field("instr_index", MASK_W'(instr_index), MASK_W'(want.idx));
				check_field("raw_mask", raw_mask, want.raw);
				check_field("war_mask", war_mask, want.war);
				check_field("waw_mask", waw_mask, want.waw);
				check_field("mem_mask", mem_mask, want.mem);
				check_field("window_overflow", MASK_W'(window_overflow), MASK_W'(want.ovf));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("register_memory_dependency_matrix_core: mismatch");
			$finish;
		end
	end

	initial begin
		instr_t it;
		int len, hi, boff, kind, done_rand;
		clear_program();
		add_row(row_t'{make_instr(1'b1, 31, 31, 31, 1'b0, 1'b0, 0), 1, 1'b1,
			no_edges(0, 1'b0)});
		add_row(row_t'{make_instr(1'b0, 31, 31, 0, 1'b0, 1'b0, 0), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 0, 31, 31, 1'b0, 1'b0, 0), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 5, 0, 0, 1'b0, 1'b0, 0), 1, 1'b1,
			no_edges(3, 1'b0)});
		add_row(row_t'{make_instr(1'b0, 0, 5, 31, 1'b1, 1'b1, 0), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 1, 5, 0, 1'b1, 1'b0, 3), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 2, 5, 0, 1'b1, 1'b0, -1), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 3, 5, 0, 1'b1, 1'b0, 4), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 0, 5, 2, 1'b1, 1'b1, 7), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 0, 0, 3, 1'b1, 1'b1, 0), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 4, 0, 0, 1'b1, 1'b0, 1), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 6, 6, 0, 1'b1, 1'b0, -2048), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 0, 6, 6, 1'b1, 1'b1, 2047), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 0, 6, 1, 1'b1, 1'b1, -2045), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 7, 6, 0, 1'b1, 1'b0, 2044), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 6, 6, 6, 1'b0, 1'b1, 0), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 0, 0, 0, 1'b0, 1'b0, 0), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b1, 0, 5, 6, 1'b1, 1'b0, 0), 1, 1'b1,
			no_edges(0, 1'b0)});
		add_row(row_t'{make_instr(1'b0, 1, 1, 0, 1'b0, 1'b0, -1), DEPTH - 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 9, 9, 9, 1'b1, 1'b1, 5), 2, 1'b1,
			no_edges(0, 1'b1)});
		add_row(row_t'{make_instr(1'b1, 8, 8, 8, 1'b1, 1'b1, -1), 1, 1'b1,
			no_edges(0, 1'b0)});
		add_row(row_t'{make_instr(1'b0, 8, 8, 0, 1'b1, 1'b0, 2), 1, 1'b0, '0});
		add_row(row_t'{make_instr(1'b0, 0, 8, 8, 1'b1, 1'b1, -4), 1, 1'b0, '0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 9;
		recv_idle_pct = 51;
		for (int n = 0; n < n_rows; n++) begin
			for (int j = 0; j < dir[n].reps; j++) begin
				send_instr(dir[n].ins);
				it = dir[n].ins;
				if (dir[n].typed) begin
					void'(derive_edges(it));
					queue_edges(dir[n].want);
				end else begin
					queue_edges(derive_edges(it));
				end
			end
		end

		done_rand = 0;
		while (done_rand < RAND_ITEMS) begin
			if (done_rand < RAND_ITEMS / 3) begin
				send_idle_pct = 9;
				recv_idle_pct = 51;
			end else if (done_rand < 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			kind = $urandom_range(99);
			hi = $urandom_range(31, 2);
			boff = $urandom_range(4095);
			len = (kind < 5) ? $urandom_range(70, 60) : $urandom_range(24, 1);
			for (int j = 0; j < len; j++) begin
				if (kind < 85) begin
					it.start = (j == 0);
					it.rd = REG_W'($urandom_range(hi));
					it.rs1 = REG_W'($urandom_range(hi));
					it.rs2 = REG_W'($urandom_range(hi));
					it.mem = ($urandom_range(99) < 40);
					it.st = $urandom_range(1) != 0;
					if ($urandom_range(9) == 0)
						it.off = OFF_W'($urandom_range(4095));
					else
						it.off = OFF_W'(boff + $urandom_range(8) - 4);
				end else begin
					it.start = ($urandom_range(99) < 20);
					it.rd = REG_W'($urandom_range(31));
					it.rs1 = REG_W'($urandom_range(31));
					it.rs2 = REG_W'($urandom_range(31));
					it.mem = $urandom_range(1) != 0;
					it.st = $urandom_range(1) != 0;
					it.off = OFF_W'($urandom_range(4095));
				end
				send_instr(it);
				queue_edges(derive_edges(it));
				done_rand++;
			end
		end
		in_valid <= 1'b0;

		while (due_wr != due_rd)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("register_memory_dependency_matrix_core: match");
		else
			$display("register_memory_dependency_matrix_core: mismatch");
		$finish;
	end

endmodule

>>> register_memory_dependency_matrix_core.f
sv/rmdm_pkg.sv
sv/rmdm_ram.sv
sv/rmdm_ctrl.sv
sv/rmdm_dp.sv
sv/register_memory_dependency_matrix_core.sv
dv/tb_register_memory_dependency_matrix_core.sv
